### sv/bpfq_pkg.sv
package bpfq_pkg;

  localparam int unsigned LevelsDef    = 16;
  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned ElemBitsDef  = 32;
  localparam logic [3:0]  MaxLevelRst  = 4'd15;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cmd_t;

endpackage

### sv/bpfq_cell.sv
module bpfq_cell import bpfq_pkg::*; #(
  parameter int unsigned PRIO_W    = $clog2(LevelsDef),
  parameter int unsigned ELEM_BITS = ElemBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [PRIO_W-1:0]    new_prio_i,
  input  logic [ELEM_BITS-1:0] new_value_i,
  input  logic                 left_valid_i,
  input  logic [PRIO_W-1:0]    left_prio_i,
  input  logic [ELEM_BITS-1:0] left_value_i,
  input  logic                 left_keep_i,
  input  logic                 right_valid_i,
  input  logic [PRIO_W-1:0]    right_prio_i,
  input  logic [ELEM_BITS-1:0] right_value_i,
  output logic                 valid_o,
  output logic [PRIO_W-1:0]    prio_o,
  output logic [ELEM_BITS-1:0] value_o,
  output logic                 keep_o
);

  logic                 valid_q, valid_d;
  logic [PRIO_W-1:0]    prio_q, prio_d;
  logic [ELEM_BITS-1:0] value_q, value_d;

  // entry stays put on insert when it is at the same or a more urgent level
  assign keep_o = valid_q && (prio_q <= new_prio_i);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    value_d = value_q;
    if (cmd_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          valid_d = 1'b1;
          prio_d  = new_prio_i;
          value_d = new_value_i;
        end else begin
          valid_d = left_valid_i;
          prio_d  = left_prio_i;
          value_d = left_value_i;
        end
      end
    end else if (cmd_i.deq) begin
      valid_d = right_valid_i;
      prio_d  = right_prio_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q  <= prio_d;
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign prio_o  = prio_q;
  assign value_o = value_q;

endmodule

### sv/bucket_priority_fifo_queue_top.sv
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | opcode_i, element_i, priority_req_i
// out     | out | out_valid_o / out_stall_i| removed_element_o .. status_o
// cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_data_i (max_level)
//
// The cell row updates at the input transfer; the output register then
// loads from cell 0 once it holds no untaken result.
// in_stall_o is high from the input transfer until that load, so a new
// item is taken only after the previous result has been loaded.
// Reset (async, active low) empties every cell and sets max_level to 15.
module bucket_priority_fifo_queue_top import bpfq_pkg::*; #(
  parameter int unsigned LEVELS    = LevelsDef,
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned ELEM_BITS = ElemBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] element_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] removed_element_o,
  output logic [31:0] head_element_o,
  output logic [3:0]  head_priority_o,
  output logic [6:0]  count_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned PRIO_W = $clog2(LEVELS);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic [3:0]           max_level_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 busy_q;
  status_e              status_q, status_d;
  logic [ELEM_BITS-1:0] removed_q, removed_d;

  logic                 out_valid_q;
  logic [31:0]          out_removed_q, out_head_q;
  logic [3:0]           out_prio_q;
  logic [6:0]           out_count_q;
  logic                 out_empty_q;
  status_e              out_status_q;

  logic                 in_xfer, load;
  op_e                  op;
  logic                 range_bad, full, empty;
  cmd_t                 cmd;
  logic [PRIO_W-1:0]    new_prio;
  logic [ELEM_BITS-1:0] new_value;

  logic                 cell_valid [CAPACITY];
  logic [PRIO_W-1:0]    cell_prio  [CAPACITY];
  logic [ELEM_BITS-1:0] cell_value [CAPACITY];
  logic                 cell_keep  [CAPACITY];

  logic [63:0]          head_wide, removed_wide;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_xfer     = in_valid_i && !busy_q;
  assign load        = busy_q && (!out_valid_q || !out_stall_i);

  assign op        = op_e'(opcode_i);
  assign range_bad = (priority_req_i > 8'(max_level_q)) ||
                     ({1'b0, priority_req_i} >= 9'(LEVELS));
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign new_prio  = PRIO_W'(priority_req_i);
  assign new_value = ELEM_BITS'(element_i);

  always_comb begin
    cmd       = '0;
    count_d   = count_q;
    status_d  = status_q;
    removed_d = removed_q;
    if (in_xfer) begin
      removed_d = '0;
      status_d  = ST_OK;
      unique case (op)
        OP_ENQ: begin
          if (range_bad) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.enq = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.deq   = 1'b1;
            count_d   = count_q - CNT_W'(1);
            removed_d = cell_value[0];
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 lv, lk, rv;
    logic [PRIO_W-1:0]    lp, rp;
    logic [ELEM_BITS-1:0] lval, rval;

    if (i == 0) begin : g_first
      assign lv   = 1'b0;
      assign lp   = '0;
      assign lval = '0;
      assign lk   = 1'b1;
    end else begin : g_mid
      assign lv   = cell_valid[i-1];
      assign lp   = cell_prio[i-1];
      assign lval = cell_value[i-1];
      assign lk   = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = 1'b0;
      assign rp   = '0;
      assign rval = '0;
    end else begin : g_inner
      assign rv   = cell_valid[i+1];
      assign rp   = cell_prio[i+1];
      assign rval = cell_value[i+1];
    end

    bpfq_cell #(
      .PRIO_W    (PRIO_W),
      .ELEM_BITS (ELEM_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_prio_i    (new_prio),
      .new_value_i   (new_value),
      .left_valid_i  (lv),
      .left_prio_i   (lp),
      .left_value_i  (lval),
      .left_keep_i   (lk),
      .right_valid_i (rv),
      .right_prio_i  (rp),
      .right_value_i (rval),
      .valid_o       (cell_valid[i]),
      .prio_o        (cell_prio[i]),
      .value_o       (cell_value[i]),
      .keep_o        (cell_keep[i])
    );
  end

  assign head_wide    = 64'(cell_value[0]);
  assign removed_wide = 64'(removed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MaxLevelRst;
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_level_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
    if (load) begin
      out_removed_q <= removed_wide[31:0];
      out_head_q    <= cell_valid[0] ? head_wide[31:0] : 32'd0;
      out_prio_q    <= cell_valid[0] ? 4'(cell_prio[0]) : 4'd0;
      out_count_q   <= 7'(count_q);
      out_empty_q   <= (count_q == '0);
      out_status_q  <= status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign removed_element_o = out_removed_q;
  assign head_element_o    = out_head_q;
  assign head_priority_o   = out_prio_q;
  assign count_o           = out_count_q;
  assign is_empty_o        = out_empty_q;
  assign status_o          = out_status_q;

`ifndef SYNTHESIS
  a_count_matches_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_valid[0])
    else $error("count and head cell disagree");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_sorted_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_valid[0] && (cell_prio[0] <= cell_prio[1])))
    else $error("front cells out of order");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op == OP_DEQ) && !empty) |=>
      (count_q == $past(count_q) - CNT_W'(1)))
    else $error("dequeue did not decrement count");

  a_load_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load) |=> (out_valid_q && !busy_q))
    else $error("result not presented after load");
`endif

endmodule

### dv/bucket_priority_fifo_queue_top_tb.sv
module bucket_priority_fifo_queue_top_tb import bpfq_pkg::*;;

  localparam int unsigned NUM_LEVELS = LevelsDef;
  localparam int unsigned CAP        = CapacityDef;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 5000;

  typedef struct packed {
    logic [31:0] removed;
    logic [31:0] head;
    logic [3:0]  head_prio;
    logic [6:0]  count;
    logic        is_empty;
    status_e     status;
  } queue_result_t;

  class bucket_queue_sb;
    logic [31:0]   level_fifo[NUM_LEVELS][$];
    int unsigned   stored;
    logic [3:0]    max_lvl;
    queue_result_t expected_results[$];
    int unsigned   errors;

    function new();
      stored  = 0;
      max_lvl = MaxLevelRst;
      errors  = 0;
    endfunction

    function int first_level();
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
        if (level_fifo[lv].size() != 0) return lv;
      end
      return NUM_LEVELS;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // predict the queue after one accepted operation
    function void apply_op(op_e op, logic [31:0] elem, logic [7:0] prio);
      queue_result_t r;
      int lv;
      r = '0;
      r.status = ST_OK;
      if (op == OP_ENQ) begin
        if (prio > max_lvl || prio >= NUM_LEVELS) begin
          r.status = ST_RANGE;
        end else if (stored >= CAP) begin
          r.status = ST_FULL;
        end else begin
          level_fifo[prio].push_back(elem);
          stored++;
        end
      end else begin
        lv = first_level();
        if (lv >= NUM_LEVELS) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = level_fifo[lv].pop_front();
          stored--;
        end
      end
      lv = first_level();
      if (lv < NUM_LEVELS) begin
        r.head      = level_fifo[lv][0];
        r.head_prio = lv[3:0];
      end
      r.count    = stored[6:0];
      r.is_empty = (stored == 0);
      expected_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t act);
      queue_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transfer: actual %h", $time, act);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      cmp_field("removed_element", exp_r.removed, act.removed);
      cmp_field("head_element", exp_r.head, act.head);
      cmp_field("head_priority", exp_r.head_prio, act.head_prio);
      cmp_field("count", exp_r.count, act.count);
      cmp_field("is_empty", exp_r.is_empty, act.is_empty);
      cmp_field("status", exp_r.status, act.status);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [31:0] element_i;
  logic [7:0]  priority_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] removed_element_o;
  logic [31:0] head_element_o;
  logic [3:0]  head_priority_o;
  logic [6:0]  count_o;
  logic        is_empty_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;

  bucket_queue_sb sb;
  bit             hold_req;
  logic [3:0]     cur_max_lvl;
  int unsigned    idle_cycles;

  bucket_priority_fifo_queue_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .element_i        (element_i),
    .priority_req_i   (priority_req_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .removed_element_o(removed_element_o),
    .head_element_o   (head_element_o),
    .head_priority_o  (head_priority_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .status_o         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int unsigned   mode;
    int unsigned   mode_left;
    int unsigned   hold_left;
    bit            hold_taken;
    logic          stall;
    queue_result_t act;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    sb          = new();
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        act.removed   = removed_element_o;
        act.head      = head_element_o;
        act.head_prio = head_priority_o;
        act.count     = count_o;
        act.is_empty  = is_empty_o;
        act.status    = status_e'(status_o);
        sb.check_result(act);
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        stall      = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 99) < 25);
          2: stall = ($urandom_range(0, 99) < 50);
          default: stall = ($urandom_range(0, 99) < 85);
        endcase
      end
      out_stall_i <= stall;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_op(input op_e op, input logic [31:0] elem, input logic [7:0] prio);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    element_i      <= elem;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.apply_op(op, elem, prio);
  endtask

  task automatic idle_in(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_in(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_level(input logic [3:0] lvl);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lvl;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.max_lvl  = lvl;
    cur_max_lvl = lvl;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned enq_pct);
    int unsigned burst;
    op_e         op;
    logic [31:0] elem;
    logic [7:0]  prio;
    burst = $urandom_range(1, 16);
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        idle_in($urandom_range(1, 6));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
      end
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      case ($urandom_range(0, 9))
        0: elem = 32'h0;
        1: elem = 32'hffff_ffff;
        default: elem = $urandom;
      endcase
      if (op == OP_ENQ && $urandom_range(0, 99) < 85) begin
        prio = 8'($urandom_range(0, cur_max_lvl));
      end else begin
        prio = 8'($urandom_range(0, 255));
      end
      send_op(op, elem, prio);
      burst--;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_ENQ;
    element_i      = '0;
    priority_req_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    hold_req       = 1'b0;
    cur_max_lvl    = MaxLevelRst;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty dequeue, level and element extremes, range drops
    send_op(OP_DEQ, 32'h1357_9bdf, 8'd0);
    send_op(OP_ENQ, 32'h0000_0000, 8'd15);
    send_op(OP_ENQ, 32'hffff_ffff, 8'd0);
    send_op(OP_ENQ, 32'hdead_beef, 8'd16);
    send_op(OP_ENQ, 32'hcafe_f00d, 8'd255);
    send_op(OP_DEQ, 32'hffff_ffff, 8'd255);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_ENQ, 32'h0000_1234, 8'd9);
    send_op(OP_ENQ, 32'haaaa_aaaa, 8'd3);
    send_op(OP_ENQ, 32'h5555_5555, 8'd3);

    // lowered limit: drops above 0, older levels still drain
    write_max_level(4'd0);
    send_op(OP_ENQ, 32'h0bad_0001, 8'd1);
    send_op(OP_ENQ, 32'h0000_0077, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);
    send_op(OP_DEQ, 32'h0, 8'd0);

    // fill past capacity; the receiver also takes its one long hold-off here
    write_max_level(4'd15);
    hold_req = 1'b1;
    run_random(90, 92);
    run_random(70, 12);

    write_max_level(4'd7);
    run_random(60, 55);
    write_max_level(4'd0);
    run_random(40, 60);
    write_max_level(4'($urandom_range(1, 14)));
    run_random(60, 50);
    write_max_level(4'd15);
    run_random(80, 50);

    idle_in(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### bucket_priority_fifo_queue_top.f
sv/bpfq_pkg.sv
sv/bpfq_cell.sv
sv/bucket_priority_fifo_queue_top.sv
dv/bucket_priority_fifo_queue_top_tb.sv
